/* hw/rtl/sab_pkg.sv */
// Package for the straight-alpha source-over blender.
// Shared types, register indexes and fixed-point constants; no dependencies.
package sab_pkg;

    localparam logic [23:0] DEN3 = 24'd16581375;  // 255^3

    typedef enum logic [2:0] {
        REG_SRC_RED       = 3'd0,
        REG_SRC_GREEN     = 3'd1,
        REG_SRC_BLUE      = 3'd2,
        REG_SRC_ALPHA     = 3'd3,
        REG_LAYER_OPACITY = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] opacity;
    } t_cfg;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
        logic [7:0] a;
    } t_pix;

    // front -> back: blend numerators, lane 0 blue, 1 green, 2 red
    typedef struct packed {
        logic            pass;
        t_pix            dst;
        logic [31:0]     a;
        logic [2:0][39:0] c;
    } t_mid;

endpackage

/* hw/rtl/sab_fifo.sv */
// Small register queue with full/empty flags.
// Generic payload width; no package dependency.
module sab_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

/* hw/rtl/sab_front.sv */
// Front end: accepts pixels, forms source alpha and the blend numerators.
// Five-stage multiply pipeline; depends on sab_pkg.
module sab_front
    import sab_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_mask_value,
    input  t_pix       i_dst,
    output logic       o_valid,
    input  logic       i_ready,
    output t_mid       o_item
);
    logic [4:0]       r_v;
    t_pix             r_dst [4];
    logic [15:0]      r_mc;
    logic [23:0]      r_sa;
    logic [31:0]      r_dai, r_ts, r_a4;
    logic [2:0][31:0] r_ssa;
    logic [2:0][39:0] r_p, r_s255;
    logic [1:0]       r_pass;
    logic             en;
    t_mid             r_out;

    assign en      = !r_v[4] || i_ready;
    assign o_full  = !en;
    assign o_valid = r_v[4];
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[3:0], i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dst[0] <= i_dst;
            r_mc     <= 16'(i_mask_value) * 16'(i_cfg.alpha);
            r_dst[1] <= r_dst[0];
            r_sa     <= 24'(r_mc) * 24'(i_cfg.opacity);
            r_dst[2] <= r_dst[1];
            r_dai    <= 32'(r_dst[1].a) * 32'(DEN3 - r_sa);
            r_ssa[0] <= 32'(i_cfg.blue) * 32'(r_sa);
            r_ssa[1] <= 32'(i_cfg.green) * 32'(r_sa);
            r_ssa[2] <= 32'(i_cfg.red) * 32'(r_sa);
            r_ts     <= (32'(r_sa) << 8) - 32'(r_sa);
            r_pass[0] <= (r_sa == '0);
            r_dst[3] <= r_dst[2];
            r_pass[1] <= r_pass[0];
            r_a4     <= r_ts + r_dai;
            r_p[0]   <= 40'(r_dst[2].b) * 40'(r_dai);
            r_p[1]   <= 40'(r_dst[2].g) * 40'(r_dai);
            r_p[2]   <= 40'(r_dst[2].r) * 40'(r_dai);
            for (int l = 0; l < 3; l++) begin
                r_s255[l] <= (40'(r_ssa[l]) << 8) - 40'(r_ssa[l]);
            end
            r_out.pass <= r_pass[1];
            r_out.dst  <= r_dst[3];
            r_out.a    <= r_a4;
            for (int l = 0; l < 3; l++) begin
                r_out.c[l] <= r_s255[l] + r_p[l];
            end
        end
    end
endmodule

/* hw/rtl/sab_back.sv */
// Back end: rounded color divisions, one quotient bit per stage over nine
// stages, alpha by reciprocal multiply, plus pass-through select; depends on sab_pkg.
module sab_back
    import sab_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_mid i_item,
    output logic o_valid,
    input  logic i_ready,
    output t_pix o_pix
);
    localparam int NS = 10;
    localparam logic [24:0] DEN3X2 = {DEN3, 1'b0};
    // floor(2^40 / (2 * 255^3)); estimate is exact or one low for numerators below 2^34
    localparam logic [15:0] RECIP = 16'((64'd1 << 40) / (64'd2 * 64'(DEN3)));

    typedef struct packed {
        logic             pass;
        t_pix             dst;
        logic [2:0][41:0] rem;
        logic [2:0][32:0] dv;
        logic [2:0][8:0]  q;
        logic [33:0]      ay;
        logic [49:0]      ap;
        logic [8:0]       aq;
    } t_div;

    function automatic t_div div_step(input t_div x, input int k);
        t_div        y;
        logic [41:0] dk;
        y = x;
        for (int l = 0; l < 3; l++) begin
            dk = 42'(x.dv[l]) << k;
            if (x.rem[l] >= dk) begin
                y.rem[l]  = x.rem[l] - dk;
                y.q[l][k] = 1'b1;
            end
        end
        return y;
    endfunction

    function automatic t_div alpha_step(input t_div x, input int s);
        t_div       y;
        logic [8:0] qe;
        y  = x;
        qe = x.ap[48:40];
        if (s == 1) begin
            y.ap = 50'(x.ay) * 50'(RECIP);
        end else if (s == 2) begin
            y.aq = (35'(x.ay) >= 35'(qe + 9'd1) * 35'(DEN3X2)) ? qe + 9'd1 : qe;
        end
        return y;
    endfunction

    function automatic logic [7:0] sat8(input logic [8:0] q);
        return q[8] ? 8'hFF : q[7:0];
    endfunction

    logic [NS-1:0] r_v;
    t_div          r_st [NS];
    t_div          n_st0;
    logic          en;

    assign en      = !r_v[NS-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[NS-1];

    always_comb begin
        n_st0.pass = i_item.pass;
        n_st0.dst  = i_item.dst;
        n_st0.q    = '0;
        for (int l = 0; l < 3; l++) begin
            n_st0.rem[l] = {1'b0, i_item.c[l], 1'b0} + 42'(i_item.a);
            n_st0.dv[l]  = {i_item.a, 1'b0};
        end
        n_st0.ay = 34'({i_item.a, 1'b0}) + 34'(DEN3);
        n_st0.ap = '0;
        n_st0.aq = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0] <= n_st0;
        end
    end

    for (genvar s = 1; s < NS; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_st[s] <= alpha_step(div_step(r_st[s-1], NS - 1 - s), s);
            end
        end
    end

    always_comb begin
        if (r_st[NS-1].pass) begin
            o_pix = r_st[NS-1].dst;
        end else begin
            o_pix.b = sat8(r_st[NS-1].q[0]);
            o_pix.g = sat8(r_st[NS-1].q[1]);
            o_pix.r = sat8(r_st[NS-1].q[2]);
            o_pix.a = sat8(r_st[NS-1].aq);
        end
    end
endmodule

/* hw/rtl/straight_alpha_over_blend.sv */
// Straight-alpha source-over blender, top level; depends on sab_pkg,
// sab_front, sab_back and sab_fifo.
// One pixel per clock sustained while the consumer keeps popping. A pixel
// passes through five multiply stages in the front end, the queue between
// front and back, one setup stage and nine one-bit divide stages in the back
// end, and the result queue. Each end stalls on its own; the queues absorb
// short stalls of the consumer. Write configuration only while no pixel is
// in flight.
module straight_alpha_over_blend
    import sab_pkg::*;
#(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_mask_value,
    input  logic [7:0] i_dest_blue,
    input  logic [7:0] i_dest_green,
    input  logic [7:0] i_dest_red,
    input  logic [7:0] i_dest_alpha,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_alpha
);
    t_cfg r_cfg;
    t_pix dst, bk_pix, out_pix;
    t_mid f_item, m_item;
    logic f_valid, m_full, m_empty, b_ready, b_valid, o_fifo_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red     <= 8'd0;
            r_cfg.green   <= 8'd0;
            r_cfg.blue    <= 8'd0;
            r_cfg.alpha   <= 8'd255;
            r_cfg.opacity <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SRC_RED:       r_cfg.red     <= i_cfg_data;
                REG_SRC_GREEN:     r_cfg.green   <= i_cfg_data;
                REG_SRC_BLUE:      r_cfg.blue    <= i_cfg_data;
                REG_SRC_ALPHA:     r_cfg.alpha   <= i_cfg_data;
                REG_LAYER_OPACITY: r_cfg.opacity <= i_cfg_data;
                default:           r_cfg         <= r_cfg;
            endcase
        end
    end

    assign dst = '{b: i_dest_blue, g: i_dest_green, r: i_dest_red, a: i_dest_alpha};

    sab_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_push       (push),
        .o_full       (full),
        .i_mask_value (i_mask_value),
        .i_dst        (dst),
        .o_valid      (f_valid),
        .i_ready      (!m_full),
        .o_item       (f_item)
    );

    sab_fifo #(.W($bits(t_mid)), .DEPTH(MID_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_item),
        .o_full  (m_full),
        .i_pop   (b_ready),
        .o_data  (m_item),
        .o_empty (m_empty)
    );

    sab_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!m_empty),
        .o_ready (b_ready),
        .i_item  (m_item),
        .o_valid (b_valid),
        .i_ready (!o_fifo_full),
        .o_pix   (bk_pix)
    );

    sab_fifo #(.W($bits(t_pix)), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_valid),
        .i_data  (bk_pix),
        .o_full  (o_fifo_full),
        .i_pop   (pop),
        .o_data  (out_pix),
        .o_empty (empty)
    );

    assign o_out_blue  = out_pix.b;
    assign o_out_green = out_pix.g;
    assign o_out_red   = out_pix.r;
    assign o_out_alpha = out_pix.a;
endmodule

/* hw/rtl/sab_checker.sv */
// Port-level checks for the blender, bound to the top level.
// Depends only on the top level's ports.
module sab_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_alpha,
    input logic [7:0] o_out_blue
);
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("results present after reset");
    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input blocked after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("waiting result dropped");
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_out_alpha) && $stable(o_out_blue))
        else $error("waiting result changed");
endmodule

bind straight_alpha_over_blend sab_checker u_sab_checker (.*);
